[rtl/core/usb_pkg.sv]
package usb_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int ID_W       = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = 5;   // covers any slot number up to 31
    localparam int CNT_W      = 6;   // holds a count up to 32
    localparam int PTR_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int OUTCOME_W  = 2;

    localparam logic [CFG_W-1:0] SLOTS_RST = CFG_W'(16);

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACE = 2'd2;

    // priority state rippling from slot 0 upward: first hit, first empty
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             empty;
        logic [IDX_W-1:0] empty_idx;
    } t_chain;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_write;

endpackage

[rtl/core/unit_slot_binder.sv]
// Slot binder: maps 32-bit object ids onto a fully associative table of SLOTS
// unit slots, one cell per slot.
// Request channel: start/busy. A beat is taken on a rising edge with start
// high and busy low; busy is high for the one cycle the request is resolved.
// Result: o_done strobes for exactly one cycle with o_slot_index/o_outcome
// (0 hit, 1 filled an empty slot, 2 replaced the round-robin victim). The
// receiver cannot stall; every result must be taken in its strobe cycle.
// Result path: busy is registered at the accepting edge and o_done is
// registered from busy. A new request is not taken while busy is high: the
// request register is followed by the commit cycle in which the hit/empty
// ripple through the cell row resolves and the chosen cell is written.
// Config: i_cfg_valid/o_cfg_ready carries slots_in_use; ready is low while a
// request is in flight. Zero acts as 1, values above SLOTS act as SLOTS.
// Reset: all slots empty, victim pointer zero, slots_in_use = 16, no
// request pending.
module unit_slot_binder #(
    parameter int SLOTS = usb_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [usb_pkg::ID_W-1:0]          i_object_id,
    output logic                              o_done,
    output logic [usb_pkg::SLOT_OUT_W-1:0]    o_slot_index,
    output logic [usb_pkg::OUTCOME_W-1:0]     o_outcome,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [usb_pkg::CFG_W-1:0]         i_cfg_slots_in_use
);

    localparam logic [usb_pkg::CNT_W-1:0] SLOTS_CNT = usb_pkg::CNT_W'(SLOTS);

    logic                              r_pend;
    logic [usb_pkg::ID_W-1:0]          r_req_id;
    logic [usb_pkg::CFG_W-1:0]         r_slots;
    logic [usb_pkg::PTR_W-1:0]         r_victim;
    logic [usb_pkg::PTR_W-1:0]         n_victim;
    logic                              r_done;
    logic [usb_pkg::SLOT_OUT_W-1:0]    r_slot_index;
    logic [usb_pkg::OUTCOME_W-1:0]     r_outcome;

    logic [usb_pkg::CNT_W-1:0]         raw_count;
    logic [usb_pkg::CNT_W-1:0]         count;
    logic [usb_pkg::PTR_W-1:0]         victim_eff;
    logic [usb_pkg::IDX_W-1:0]         sel_idx;
    logic [usb_pkg::OUTCOME_W-1:0]     sel_outcome;
    usb_pkg::t_chain                   chain [SLOTS+1];
    usb_pkg::t_chain                   last;
    usb_pkg::t_write                   wr;

    assign busy        = r_pend;
    assign o_cfg_ready = !r_pend;
    assign o_done       = r_done;
    assign o_slot_index = r_slot_index;
    assign o_outcome    = r_outcome;

    assign raw_count = usb_pkg::CNT_W'(r_slots);

    always_comb begin
        priority if (raw_count == '0) begin
            count = usb_pkg::CNT_W'(1);
        end else if (raw_count > SLOTS_CNT) begin
            count = SLOTS_CNT;
        end else begin
            count = raw_count;
        end
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        usb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req_id (r_req_id),
            .i_count  (count),
            .i_write  (wr),
            .i_chain  (chain[g]),
            .o_chain  (chain[g+1])
        );
    end

    assign last = chain[SLOTS];

    // pointer past the active range restarts at slot 0
    assign victim_eff = ({1'b0, r_victim} >= count) ? '0 : r_victim;

    always_comb begin
        n_victim = r_victim;
        priority if (last.hit) begin
            sel_idx     = last.hit_idx;
            sel_outcome = usb_pkg::OUTCOME_HIT;
        end else if (last.empty) begin
            sel_idx     = last.empty_idx;
            sel_outcome = usb_pkg::OUTCOME_FILL;
        end else begin
            sel_idx     = usb_pkg::IDX_W'(victim_eff);
            sel_outcome = usb_pkg::OUTCOME_REPLACE;
            if (r_pend) begin
                n_victim = victim_eff + usb_pkg::PTR_W'(1);
            end
        end
    end

    assign wr.en  = r_pend && !last.hit;
    assign wr.idx = sel_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_victim <= '0;
            r_slots  <= usb_pkg::SLOTS_RST;
        end else begin
            r_pend   <= start && !r_pend;
            r_done   <= r_pend;
            r_victim <= n_victim;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slots <= i_cfg_slots_in_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_pend) begin
            r_req_id <= i_object_id;
        end
        if (r_pend) begin
            r_slot_index <= sel_idx[usb_pkg::SLOT_OUT_W-1:0];
            r_outcome    <= sel_outcome;
        end
    end

`ifndef SYNTHESIS
    a_accept_then_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing after accepted request");

    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_victim_only_on_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome != usb_pkg::OUTCOME_REPLACE) |-> r_victim == $past(r_victim))
        else $error("victim pointer moved without a replacement");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_outcome == usb_pkg::OUTCOME_HIT || o_outcome == usb_pkg::OUTCOME_FILL
                    || o_outcome == usb_pkg::OUTCOME_REPLACE))
        else $error("illegal outcome code");
`endif

endmodule

[rtl/core/usb_cell.sv]
module usb_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [usb_pkg::ID_W-1:0]    i_req_id,
    input  logic [usb_pkg::CNT_W-1:0]   i_count,
    input  usb_pkg::t_write             i_write,
    input  usb_pkg::t_chain             i_chain,
    output usb_pkg::t_chain             o_chain
);

    localparam logic [usb_pkg::IDX_W-1:0] MY_IDX = usb_pkg::IDX_W'(IDX);

    logic [usb_pkg::ID_W-1:0] r_id;
    logic                     r_valid;
    logic                     active;
    logic                     hit_here;
    logic                     empty_here;
    logic                     wr_here;

    assign active     = {1'b0, MY_IDX} < i_count;
    assign hit_here   = active && r_valid && (r_id == i_req_id);
    assign empty_here = active && !r_valid;
    assign wr_here    = i_write.en && (i_write.idx == MY_IDX);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.hit && hit_here) begin
            o_chain.hit     = 1'b1;
            o_chain.hit_idx = MY_IDX;
        end
        if (!i_chain.empty && empty_here) begin
            o_chain.empty     = 1'b1;
            o_chain.empty_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_here) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_id <= i_req_id;
        end
    end

endmodule
